// ===== sv/mwps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwps_pkg - shared types and constants for the phase synthesiser
// Phase and sample widths, queue geometry, configuration register indexes and
// the quarter-wave sine magnitude tables, built at elaboration.
// ----------------------------------------------------------------------------
package mwps_pkg;

  localparam int PHASE_W         = 32;
  localparam int SAMPLE_W        = 8;
  localparam int SINE_INDEX_BITS = 10;
  localparam int SINE_QB         = SINE_INDEX_BITS - 2;
  localparam int SINE_QUARTER    = 1 << SINE_QB;
  localparam int SINE_MAG_W      = 7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = CFG_IDX_W'(1);

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd28633115;
  localparam logic [PHASE_W-1:0] PHASE_HALF       = 32'h8000_0000;

  typedef enum logic [1:0] {
    WAVE_SAW,
    WAVE_SINE,
    WAVE_SQUARE,
    WAVE_TRIANGLE
  } wave_t;

  localparam wave_t WAVE_RESET = WAVE_SINE;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    wave_t              wave;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Q62 fixed point helpers, elaboration only
  localparam logic [63:0] Q62_ONE     = 64'd1 << 62;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] QB_MASK     = (64'd1 << SINE_QB) - 64'd1;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = {32'd0, a[31:0]};
    ah  = {32'd0, a[63:32]};
    bl  = {32'd0, b[31:0]};
    bh  = {32'd0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    lo  = {mid[31:0], ll[31:0]};
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  // Taylor series; divisors are (2n)(2n+1)
  function automatic logic [63:0] sin_q62(input logic [63:0] x);
    logic [63:0] x2, term, sum, p;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 20; n++) begin
      p = mul_q62(term, x2);
      case (n)
        1:       term = p / 64'd6;
        2:       term = p / 64'd20;
        3:       term = p / 64'd42;
        4:       term = p / 64'd72;
        5:       term = p / 64'd110;
        6:       term = p / 64'd156;
        7:       term = p / 64'd210;
        8:       term = p / 64'd272;
        9:       term = p / 64'd342;
        10:      term = p / 64'd420;
        11:      term = p / 64'd506;
        12:      term = p / 64'd600;
        13:      term = p / 64'd702;
        14:      term = p / 64'd812;
        15:      term = p / 64'd930;
        16:      term = p / 64'd1056;
        17:      term = p / 64'd1190;
        18:      term = p / 64'd1332;
        default: term = p / 64'd1482;
      endcase
      if (n[0]) sum = sum - term;
      else      sum = sum + term;
    end
    return sum;
  endfunction

  // Magnitude of 127*sin for quarter-wave step k (0 <= k < quarter)
  function automatic logic [SINE_MAG_W-1:0] sine_mag(input int unsigned k, input bit up);
    logic [63:0] x, s, m, lo_mag, hi_mag;
    x = (HALF_PI_Q62 >> SINE_QB) * 64'(k) + (((HALF_PI_Q62 & QB_MASK) * 64'(k)) >> SINE_QB);
    s = sin_q62(x);
    if (s > Q62_ONE) s = Q62_ONE;
    m      = 64'd127 * (s >> 6);
    lo_mag = m >> 56;
    hi_mag = (m + ((64'd1 << 56) - 64'd1)) >> 56;
    if (k == 0) return '0;
    return up ? SINE_MAG_W'(hi_mag) : SINE_MAG_W'(lo_mag);
  endfunction

  typedef logic [SINE_MAG_W-1:0] sine_lut_t [SINE_QUARTER];

  function automatic sine_lut_t build_sine_lut(input bit up);
    sine_lut_t t;
    for (int k = 0; k < SINE_QUARTER; k++) t[k] = sine_mag(k, up);
    return t;
  endfunction

  // floor for the upper half-wave, ceiling for the lower one
  localparam sine_lut_t SINE_FLOOR_LUT = build_sine_lut(1'b0);
  localparam sine_lut_t SINE_CEIL_LUT  = build_sine_lut(1'b1);

endpackage
`default_nettype wire

// ===== sv/multi_waveform_phase_synth_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_phase_synth_top - DDS function generator
// An accepted request is written into the four-entry work queue and moves on
// into the result register once that is free; it is popped from there.
// Throughput: one request and one sample per clock while the queue is not
// full and samples are popped; set by the phase adder and waveform stage.
// Reset (synchronous, rst_n low): phase zero, step 28633115, sine selected,
// queue and result register empty.
// ----------------------------------------------------------------------------
module multi_waveform_phase_synth_top import mwps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic                  in_tick,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [SAMPLE_W-1:0]        out_sample,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  item_t      wr_item, rd_item;
  fifo_stat_t q_stat;
  logic       q_push, q_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;

  mwps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_tick   (in_tick),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_item    (wr_item)
  );

  mwps_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (wr_item),
    .pop     (q_pop),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  mwps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (rd_item),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_sample (out_sample)
  );

  // back end drains the queue whenever the result register is free
  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("queue full while result register empty");

  a_request_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> ##2 !out_empty)
    else $error("accepted request produced no result");

  a_pop_only_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("work queue popped while empty");

endmodule
`default_nettype wire

// ===== sv/mwps_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwps_front - configuration and phase accumulator
// Holds the step and waveform registers, advances the phase on each accepted
// request with in_tick high and hands phase plus waveform to the work queue.
// ----------------------------------------------------------------------------
module mwps_front import mwps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  input  wire logic                  in_tick,
  input  wire logic                  q_full,
  output logic                       q_push,
  output item_t                      q_item
);

  logic [PHASE_W-1:0] phase_acc_r, phase_acc_nxt;
  logic [PHASE_W-1:0] phase_step_r, phase_step_nxt;
  wave_t              wave_r, wave_nxt;
  logic [PHASE_W-1:0] phase_sum;

  assign q_push    = in_push & ~q_full;
  assign phase_sum = phase_acc_r + (in_tick ? phase_step_r : '0);

  always_comb begin
    q_item.phase = phase_sum;
    q_item.wave  = wave_r;
  end

  always_comb begin
    phase_acc_nxt = q_push ? phase_sum : phase_acc_r;
  end

  always_comb begin
    phase_step_nxt = phase_step_r;
    wave_nxt       = wave_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_STEP:  phase_step_nxt = cfg_data[PHASE_W-1:0];
        CFG_WAVE_SELECT: wave_nxt       = wave_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r  <= '0;
      phase_step_r <= PHASE_STEP_RESET;
      wave_r       <= WAVE_RESET;
    end else begin
      phase_acc_r  <= phase_acc_nxt;
      phase_step_r <= phase_step_nxt;
      wave_r       <= wave_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mwps_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwps_fifo - short work queue between front and back
// Four entries of phase and waveform, first in first out.
// ----------------------------------------------------------------------------
module mwps_fifo import mwps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  item_t      wr_item,
  input  wire logic  pop,
  output item_t      rd_item,
  output fifo_stat_t stat
);

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign rd_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mwps_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwps_back - waveform generator and result register
// Turns a queued phase into an 8-bit sample of the chosen waveform and holds
// it on the result ports until popped.
// ----------------------------------------------------------------------------
module mwps_back import mwps_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  item_t                    q_item,
  input  fifo_stat_t               q_stat,
  output logic                     q_pop,
  input  wire logic                out_pop,
  output logic                     out_empty,
  output logic [SAMPLE_W-1:0]      out_sample
);

  logic                       valid_r, valid_nxt;
  logic [SAMPLE_W-1:0]        sample_r, sample_nxt;

  logic [PHASE_W+7:0]         saw_prod, tri_prod;
  logic [PHASE_W-1:0]         tri_dist;
  logic [SINE_INDEX_BITS-1:0] sine_idx;
  logic [1:0]                 quad;
  logic [SINE_QB-1:0]         sine_r, sine_k;
  logic                       at_peak;
  logic [SINE_MAG_W-1:0]      mag_lo, mag_hi;
  logic [SAMPLE_W-1:0]        sine_val;

  assign q_pop = ~q_stat.empty & (~valid_r | out_pop);

  // saw and triangle: scale by 255 and keep the top byte
  assign saw_prod = (PHASE_W+8)'(q_item.phase) * (PHASE_W+8)'(255);
  assign tri_dist = q_item.phase[PHASE_W-1] ? q_item.phase - PHASE_HALF
                                            : PHASE_HALF - q_item.phase;
  assign tri_prod = (PHASE_W+8)'(tri_dist) * (PHASE_W+8)'(255);

  // sine: quarter-wave table, mirrored in odd quadrants, negated in the lower half
  assign sine_idx = q_item.phase[PHASE_W-1 -: SINE_INDEX_BITS];
  assign quad     = sine_idx[SINE_INDEX_BITS-1 -: 2];
  assign sine_r   = sine_idx[SINE_QB-1:0];
  assign sine_k   = quad[0] ? SINE_QB'(~sine_r + SINE_QB'(1)) : sine_r;
  assign at_peak  = quad[0] & (sine_r == '0);
  assign mag_lo   = at_peak ? SINE_MAG_W'(127) : SINE_FLOOR_LUT[sine_k];
  assign mag_hi   = at_peak ? SINE_MAG_W'(127) : SINE_CEIL_LUT[sine_k];
  assign sine_val = quad[1] ? SAMPLE_W'(128) - {1'b0, mag_hi}
                            : SAMPLE_W'(128) + {1'b0, mag_lo};

  always_comb begin
    case (q_item.wave)
      WAVE_SAW:      sample_nxt = saw_prod[PHASE_W +: SAMPLE_W];
      WAVE_SINE:     sample_nxt = sine_val;
      WAVE_SQUARE:   sample_nxt = {SAMPLE_W{q_item.phase[PHASE_W-1]}};
      WAVE_TRIANGLE: sample_nxt = tri_prod[PHASE_W-1 +: SAMPLE_W];
      default:       sample_nxt = '0;
    endcase
  end

  assign valid_nxt = q_pop | (valid_r & ~out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) sample_r <= sample_nxt;
  end

  assign out_empty  = ~valid_r;
  assign out_sample = sample_r;

endmodule
`default_nettype wire

// ===== sim/mwps_sample_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mwps_sample_check - sample checker for the phase synthesiser
// Watches the register, request and sample channels, keeps its own phase
// accumulator and sine table, and compares every popped sample in order.
// ----------------------------------------------------------------------------
module mwps_sample_check import mwps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic                  in_full,
  input  wire logic                  in_tick,
  input  wire logic                  out_empty,
  input  wire logic                  out_pop,
  input  wire logic [SAMPLE_W-1:0]   out_sample,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         pending
);

  localparam logic [63:0] FX_HALF_PI = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] FX_ONE     = 64'd1 << 62;
  localparam int          ROM_N      = 1 << SINE_INDEX_BITS;

  logic [SAMPLE_W-1:0] sine_tab [ROM_N];
  logic [PHASE_W-1:0]  step_m;
  logic [PHASE_W-1:0]  phase_m;
  wave_t               wave_m;
  logic [SAMPLE_W-1:0] want_samples [$];

  // exact floor of a*b / 2^62
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] fx_sin(input logic [63:0] x);
    logic [63:0] x2, term, sum;
    x2   = fx_mul(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 20 && term != 64'd0; n++) begin
      term = fx_mul(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    return sum;
  endfunction

  // lower half-wave rounds the magnitude up, upper half-wave rounds it down
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned i);
    int unsigned qb, quarter, quad, r, k;
    logic [63:0] x, s, m, mag_dn, mag_up;
    qb      = SINE_INDEX_BITS - 2;
    quarter = 1 << qb;
    quad    = (i >> qb) & 3;
    r       = i & (quarter - 1);
    k       = (quad & 1) ? quarter - r : r;
    if (k == 0) begin
      mag_dn = 64'd0;
      mag_up = 64'd0;
    end else if (k == quarter) begin
      mag_dn = 64'd127;
      mag_up = 64'd127;
    end else begin
      x = (FX_HALF_PI >> qb) * 64'(k)
        + (((FX_HALF_PI & ((64'd1 << qb) - 64'd1)) * 64'(k)) >> qb);
      s = fx_sin(x);
      if (s > FX_ONE) s = FX_ONE;
      m      = 64'd127 * (s >> 6);
      mag_dn = m >> 56;
      mag_up = (m + ((64'd1 << 56) - 64'd1)) >> 56;
    end
    return (quad & 2) ? SAMPLE_W'(64'd128 - mag_up) : SAMPLE_W'(64'd128 + mag_dn);
  endfunction

  function automatic logic [SAMPLE_W-1:0] wave_sample(input wave_t w,
                                                     input logic [PHASE_W-1:0] ph);
    logic [63:0]        wide;
    logic [PHASE_W-1:0] gap;
    case (w)
      WAVE_SAW:    wide = (64'(ph) * 64'd255) >> 32;
      WAVE_SINE:   wide = 64'(sine_tab[ph >> (PHASE_W - SINE_INDEX_BITS)]);
      WAVE_SQUARE: wide = (ph >= PHASE_HALF) ? 64'd255 : 64'd0;
      default: begin
        gap  = (ph < PHASE_HALF) ? PHASE_HALF - ph : ph - PHASE_HALF;
        wide = (64'(gap) * 64'd255) >> 31;
      end
    endcase
    return wide[SAMPLE_W-1:0];
  endfunction

  initial begin
    for (int i = 0; i < ROM_N; i++) sine_tab[i] = sine_entry(i);
  end

  always @(posedge clk) begin : track
    string want_txt;
    if (!rst_n) begin
      step_m  = PHASE_STEP_RESET;
      phase_m = '0;
      wave_m  = WAVE_RESET;
      want_samples.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PHASE_STEP)       step_m = cfg_data;
        else if (cfg_index == CFG_WAVE_SELECT) wave_m = wave_t'(cfg_data[1:0]);
      end
      // check the pop first so a sample never pairs with a request of this edge
      if (out_pop && !out_empty) begin
        if (want_samples.size() == 0 || want_samples[0] != out_sample) begin
          want_txt = (want_samples.size() == 0) ? "none"
                                                : $sformatf("%0d", want_samples[0]);
          if (mismatches < 10)
            $display("%0t sample mismatch: expected %s, got %0d", $realtime, want_txt,
                     out_sample);
          mismatches++;
        end
        if (want_samples.size() != 0) void'(want_samples.pop_front());
      end
      if (in_push && !in_full) begin
        if (in_tick) phase_m = phase_m + step_m;
        want_samples.push_back(wave_sample(wave_m, phase_m));
      end
      pending <= want_samples.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the phase synthesiser
// Directed requests over every waveform and step extreme, then randomised
// register settings with tick requests, random idling on both sides, a long
// sample hold-off and a full drain mid-phase. Samples are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mwps_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_tick;
  logic                  out_empty;
  logic                  out_pop;
  logic [SAMPLE_W-1:0]   out_sample;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;

  bit idling   = 1'b1;
  int hold_len = 0;

  multi_waveform_phase_synth_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_tick   (in_tick),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_sample(out_sample),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mwps_sample_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_tick   (in_tick),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_sample(out_sample),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // sample side: random hold bursts, plus one long hold when asked
  initial begin
    int n;
    bit held;
    held    = 1'b0;
    out_pop <= 1'b0;
    forever begin
      if (hold_len > 0 && !held) begin
        n       = hold_len;
        held    = 1'b1;
        out_pop <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_tick(input bit t);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_tick <= t;
    do @(posedge clk); while (in_full);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait until every expected sample has been popped, then let the pipe settle
  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [PHASE_W-1:0] pick_step();
    logic [PHASE_W-1:0] s;
    case ($urandom_range(0, 6))
      0:       s = 32'd1;
      1:       s = PHASE_HALF;
      2:       s = $urandom_range(1, 4096);
      3:       s = $urandom_range(1, 32'h8000_0000);
      4:       s = $urandom;
      5:       s = PHASE_HALF - $urandom_range(0, 255);
      default: s = 32'hFFFF_FFFF - $urandom_range(0, 255);
    endcase
    return s;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] wsel;
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_tick   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: sine at the reset step, then a held tick
    repeat (3) push_tick(1'b1);
    push_tick(1'b0);
    in_push <= 1'b0;
    settle();

    // step back to phase zero exactly
    cfg_write(CFG_PHASE_STEP, 32'd0 - 32'd3 * PHASE_STEP_RESET);
    cfg_valid <= 1'b0;
    push_tick(1'b1);
    in_push <= 1'b0;
    settle();

    // half-cycle step: hits the square edge and wraps at one full cycle
    cfg_write(CFG_PHASE_STEP, PHASE_HALF);
    cfg_write(CFG_WAVE_SELECT, 32'(WAVE_SQUARE));
    cfg_valid <= 1'b0;
    repeat (3) push_tick(1'b1);
    in_push <= 1'b0;
    settle();
    cfg_write(CFG_WAVE_SELECT, 32'(WAVE_TRIANGLE));
    cfg_valid <= 1'b0;
    repeat (2) push_tick(1'b1);
    in_push <= 1'b0;
    settle();

    // smallest step, saw, wave select with junk in the upper data bits
    cfg_write(CFG_PHASE_STEP, 32'd1);
    cfg_write(CFG_WAVE_SELECT, 32'hA5A5_A5A4 | 32'(WAVE_SAW));
    cfg_valid <= 1'b0;
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    in_push <= 1'b0;
    settle();

    // zero step freezes the phase; a write to an unused index is ignored
    cfg_write(CFG_PHASE_STEP, 32'd0);
    cfg_write(CFG_IDX_W'(2), $urandom);
    cfg_write(CFG_WAVE_SELECT, 32'(WAVE_SINE));
    cfg_valid <= 1'b0;
    repeat (2) push_tick(1'b1);
    in_push <= 1'b0;
    settle();

    // largest step runs the phase backwards
    cfg_write(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    cfg_write(CFG_WAVE_SELECT, 32'(WAVE_TRIANGLE));
    cfg_valid <= 1'b0;
    repeat (3) push_tick(1'b1);
    in_push <= 1'b0;

    for (int ph = 0; ph < 14; ph++) begin
      settle();
      idling = (ph < 11);
      if (ph == 0 || $urandom_range(0, 3) != 0) cfg_write(CFG_PHASE_STEP, pick_step());
      wsel = ($urandom_range(0, 7) == 0) ? ($urandom & ~32'd3) : 32'd0;
      cfg_write(CFG_WAVE_SELECT, wsel | 32'($urandom_range(0, 3)));
      cfg_valid <= 1'b0;
      // long sample hold while requests keep coming: fills the queue
      if (ph == 3) hold_len = 80;
      for (int i = 0; i < 60; i++) begin
        if (ph == 6 && i == 30) begin
          in_push <= 1'b0;
          settle();
        end
        push_tick($urandom_range(0, 15) != 0);
      end
      in_push <= 1'b0;
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mwps_pkg.sv
sv/mwps_front.sv
sv/mwps_fifo.sv
sv/mwps_back.sv
sv/multi_waveform_phase_synth_top.sv
sim/mwps_sample_check.sv
sim/tb_top.sv
